FILE: hw/rtl/gtl_pkg.sv
// Shared types and constants for the grammar token lexer.
`default_nettype none

package gtl_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 16384;
    localparam int OFFSET_MAX         = 16383;
    localparam int OFFSET_W           = 14;
    localparam int COUNT_W            = 16;

    typedef enum logic [2:0] {
        KIND_NONTERM = 3'd0,
        KIND_TERM    = 3'd1,
        KIND_PRODUCE = 3'd2,
        KIND_PIPE    = 3'd3,
        KIND_SEMI    = 3'd4,
        KIND_END     = 3'd5,
        KIND_ERROR   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_ANGLE = 2'd1,
        ERR_QUOTE = 2'd2,
        ERR_BYTE  = 2'd3
    } t_err;

    typedef struct packed {
        t_kind                kind;
        t_err                 err;
        logic [OFFSET_W-1:0]  start;
        logic [OFFSET_W-1:0]  len;
        logic [COUNT_W-1:0]   line;
        logic [COUNT_W-1:0]   col;
    } t_token;

endpackage

`default_nettype wire

FILE: hw/rtl/gtl_scan.sv
// Scanner state, position counters and per-byte token decision.
`default_nettype none

module gtl_scan #(
    parameter int MAX_TEXT_BYTES = gtl_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    output logic               o_emit,
    output gtl_pkg::t_token    o_token
);

    localparam logic [gtl_pkg::OFFSET_W-1:0] OFFSET_LIMIT =
        (MAX_TEXT_BYTES - 1 < gtl_pkg::OFFSET_MAX) ?
        gtl_pkg::OFFSET_W'(MAX_TEXT_BYTES - 1) : gtl_pkg::OFFSET_W'(gtl_pkg::OFFSET_MAX);
    localparam logic [gtl_pkg::COUNT_W-1:0] COUNT_LIMIT = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    typedef enum logic [5:0] {
        MODE_BETWEEN = 6'b000001,
        MODE_ANGLE   = 6'b000010,
        MODE_DQUOTE  = 6'b000100,
        MODE_SQUOTE  = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_HALTED  = 6'b100000
    } t_mode;

    function automatic logic is_name_byte(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || b == CH_DASH;
    endfunction

    t_mode                        r_mode,   n_mode;
    logic [gtl_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [gtl_pkg::COUNT_W-1:0]  r_line,   n_line;
    logic [gtl_pkg::COUNT_W-1:0]  r_col,    n_col;
    logic [gtl_pkg::OFFSET_W-1:0] r_tstart, n_tstart;
    logic [gtl_pkg::COUNT_W-1:0]  r_tline,  n_tline;
    logic [gtl_pkg::COUNT_W-1:0]  r_tcol,   n_tcol;

    logic                         adv;
    logic                         mark;
    logic                         emit;
    gtl_pkg::t_kind               kind;
    gtl_pkg::t_err                err;
    logic [gtl_pkg::OFFSET_W-1:0] len;
    logic [gtl_pkg::OFFSET_W-1:0] span;
    logic                         is_zero;
    logic                         is_nl;
    logic                         quote_close;

    always_comb begin
        adv         = 1'b0;
        mark        = 1'b0;
        emit        = 1'b0;
        kind        = gtl_pkg::KIND_END;
        err         = gtl_pkg::ERR_NONE;
        len         = '0;
        n_mode      = r_mode;
        span        = r_offset - r_tstart;
        is_zero     = (i_byte == CH_NUL);
        is_nl       = (i_byte == CH_NL);
        quote_close = (r_mode == MODE_DQUOTE) ? (i_byte == CH_DQ) : (i_byte == CH_SQ);

        unique case (r_mode)
            MODE_BETWEEN: begin
                if (is_zero) begin
                    mark   = 1'b1;
                    emit   = 1'b1;
                    n_mode = MODE_HALTED;
                end else if (i_byte == CH_SPACE || i_byte == CH_TAB || is_nl) begin
                    adv = 1'b1;
                end else if (i_byte == CH_HASH) begin
                    adv    = 1'b1;
                    n_mode = MODE_COMMENT;
                end else if (i_byte == CH_LT || i_byte == CH_DQ || i_byte == CH_SQ) begin
                    mark   = 1'b1;
                    adv    = 1'b1;
                    n_mode = (i_byte == CH_LT) ? MODE_ANGLE :
                             (i_byte == CH_DQ) ? MODE_DQUOTE : MODE_SQUOTE;
                end else if (i_byte == CH_COLON || i_byte == CH_PIPE || i_byte == CH_SEMI) begin
                    mark = 1'b1;
                    adv  = 1'b1;
                    emit = 1'b1;
                    len  = gtl_pkg::OFFSET_W'(1);
                    kind = (i_byte == CH_COLON) ? gtl_pkg::KIND_PRODUCE :
                           (i_byte == CH_PIPE)  ? gtl_pkg::KIND_PIPE : gtl_pkg::KIND_SEMI;
                end else begin
                    // unexpected byte: report at its own position, do not advance
                    mark   = 1'b1;
                    emit   = 1'b1;
                    kind   = gtl_pkg::KIND_ERROR;
                    err    = gtl_pkg::ERR_BYTE;
                    len    = gtl_pkg::OFFSET_W'(1);
                    n_mode = MODE_HALTED;
                end
            end
            MODE_ANGLE: begin
                if (is_name_byte(i_byte)) begin
                    adv = 1'b1;
                end else if (i_byte == CH_GT) begin
                    adv    = 1'b1;
                    emit   = 1'b1;
                    kind   = gtl_pkg::KIND_NONTERM;
                    len    = span + gtl_pkg::OFFSET_W'(1);
                    n_mode = MODE_BETWEEN;
                end else begin
                    emit   = 1'b1;
                    kind   = gtl_pkg::KIND_ERROR;
                    err    = gtl_pkg::ERR_ANGLE;
                    len    = is_zero ? span : span + gtl_pkg::OFFSET_W'(1);
                    n_mode = MODE_HALTED;
                end
            end
            MODE_DQUOTE, MODE_SQUOTE: begin
                if (quote_close) begin
                    adv    = 1'b1;
                    emit   = 1'b1;
                    kind   = gtl_pkg::KIND_TERM;
                    len    = span + gtl_pkg::OFFSET_W'(1);
                    n_mode = MODE_BETWEEN;
                end else if (is_zero || is_nl) begin
                    emit   = 1'b1;
                    kind   = gtl_pkg::KIND_ERROR;
                    err    = gtl_pkg::ERR_QUOTE;
                    len    = is_zero ? span : span + gtl_pkg::OFFSET_W'(1);
                    n_mode = MODE_HALTED;
                end else begin
                    adv = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (is_zero) begin
                    mark   = 1'b1;
                    emit   = 1'b1;
                    n_mode = MODE_HALTED;
                end else begin
                    adv = 1'b1;
                    if (is_nl) begin
                        n_mode = MODE_BETWEEN;
                    end
                end
            end
            default: begin
                // halted: drop every byte
            end
        endcase
    end

    // position counters, saturating
    always_comb begin
        n_offset = r_offset;
        n_line   = r_line;
        n_col    = r_col;
        n_tstart = mark ? r_offset : r_tstart;
        n_tline  = mark ? r_line   : r_tline;
        n_tcol   = mark ? r_col    : r_tcol;
        if (adv) begin
            if (r_offset < OFFSET_LIMIT) begin
                n_offset = r_offset + gtl_pkg::OFFSET_W'(1);
            end
            if (i_byte == CH_NL) begin
                if (r_line != COUNT_LIMIT) begin
                    n_line = r_line + gtl_pkg::COUNT_W'(1);
                end
                n_col = '0;
            end else if (r_col != COUNT_LIMIT) begin
                n_col = r_col + gtl_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BETWEEN;
            r_offset <= '0;
            r_line   <= gtl_pkg::COUNT_W'(1);
            r_col    <= '0;
            r_tstart <= '0;
            r_tline  <= gtl_pkg::COUNT_W'(1);
            r_tcol   <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_line   <= n_line;
            r_col    <= n_col;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_tcol   <= n_tcol;
        end
    end

    assign o_emit        = emit;
    assign o_token.kind  = kind;
    assign o_token.err   = err;
    assign o_token.start = n_tstart;
    assign o_token.len   = len;
    assign o_token.line  = n_tline;
    assign o_token.col   = n_tcol;

endmodule

`default_nettype wire

FILE: hw/rtl/grammar_token_lexer.sv
// Top level of the grammar token lexer: input register, scanner, result register.
`default_nettype none

// Byte-serial lexer for BNF-style grammar text. One byte enters per cycle while
// the input is not stalled; a byte that completes a token, once accepted, passes
// the input register and then the result register before its result appears.
// Sustained rate is one byte per clock while the output is not stalled, set by
// the update of the scan mode and position counters in gtl_scan. Bytes that
// complete no token produce no transaction. After an end or error token all
// further bytes are accepted and dropped until reset.
module grammar_token_lexer #(
    parameter int MAX_TEXT_BYTES = gtl_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_token_kind,
    output logic [1:0]       o_error_kind,
    output logic [13:0]      o_start_offset,
    output logic [13:0]      o_token_length,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_column
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_out_valid;
    gtl_pkg::t_token r_tok;

    logic            out_free;
    logic            fire;
    logic            emit;
    gtl_pkg::t_token tok;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    gtl_scan #(
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_token (tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_tok <= tok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_tok.kind;
    assign o_error_kind   = r_tok.err;
    assign o_start_offset = r_tok.start;
    assign o_token_length = r_tok.len;
    assign o_start_line   = r_tok.line;
    assign o_start_column = r_tok.col;

`ifndef SYNTHESIS
    a_err_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != gtl_pkg::KIND_ERROR |-> o_error_kind == gtl_pkg::ERR_NONE)
        else $error("error kind set on a non-error token");
    a_error_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == gtl_pkg::KIND_ERROR |-> o_error_kind != gtl_pkg::ERR_NONE)
        else $error("error token without error kind");
    a_end_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == gtl_pkg::KIND_END |-> o_token_length == 14'd0)
        else $error("end token with nonzero length");
    a_symbol_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == gtl_pkg::KIND_PRODUCE ||
                        o_token_kind == gtl_pkg::KIND_PIPE ||
                        o_token_kind == gtl_pkg::KIND_SEMI) |-> o_token_length == 14'd1)
        else $error("single-byte token with wrong length");
    a_stall_needs_backup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result side is free");
`endif

endmodule

`default_nettype wire

FILE: test/grammar_token_lexer_test.sv
// Self-checking testbench for the grammar token lexer: random grammar text, scored tokens.
module grammar_token_lexer_test;

    localparam int OFFSET_LIMIT =
        (gtl_pkg::MAX_TEXT_BYTES_DEF - 1 < gtl_pkg::OFFSET_MAX) ?
        gtl_pkg::MAX_TEXT_BYTES_DEF - 1 : gtl_pkg::OFFSET_MAX;
    localparam int COUNT_LIMIT  = 65535;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    localparam string NAME_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

    typedef enum logic [2:0] {
        SCAN_BETWEEN, SCAN_ANGLE, SCAN_DQUOTE, SCAN_SQUOTE, SCAN_COMMENT, SCAN_HALTED
    } t_scan_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_token_kind;
    logic [1:0]  o_error_kind;
    logic [13:0] o_start_offset;
    logic [13:0] o_token_length;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;

    grammar_token_lexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_error_kind   (o_error_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column)
    );

    always #6 i_clk = ~i_clk;

    // Scanner state mirrored by the predictor
    t_scan_mode  scan_mode = SCAN_BETWEEN;
    logic [13:0] pos_offset = '0;
    logic [15:0] pos_line = 16'd1;
    logic [15:0] pos_col = '0;
    logic [13:0] tok_start = '0;
    logic [15:0] tok_line = 16'd1;
    logic [15:0] tok_col = '0;

    logic [7:0]      grammar_text[$];
    gtl_pkg::t_token pending_tokens[$];

    int bytes_queued = 0;
    int bytes_fed = 0;
    int tokens_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int hold_count = 0;
    int run_phase = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    string end_desc = "";

    function automatic bit is_name_char(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || b == CH_DASH;
    endfunction

    function automatic void advance_pos(logic [7:0] b);
        if (pos_offset < OFFSET_LIMIT) pos_offset++;
        if (b == CH_LF) begin
            if (pos_line < COUNT_LIMIT) pos_line++;
            pos_col = '0;
        end else if (pos_col < COUNT_LIMIT) begin
            pos_col++;
        end
    endfunction

    function automatic void mark_token();
        tok_start = pos_offset;
        tok_line  = pos_line;
        tok_col   = pos_col;
    endfunction

    function automatic gtl_pkg::t_token make_token(gtl_pkg::t_kind k, gtl_pkg::t_err e,
                                                   logic [13:0] n);
        gtl_pkg::t_token t;
        t.kind  = k;
        t.err   = e;
        t.start = tok_start;
        t.len   = n;
        t.line  = tok_line;
        t.col   = tok_col;
        return t;
    endfunction

    // Update the scanner for one byte; return 1 when the byte completes a token.
    function automatic bit scan_byte(input logic [7:0] b, output gtl_pkg::t_token tok);
        logic [13:0] span;
        bit          hit;
        span = pos_offset - tok_start;
        hit  = 1'b0;
        tok  = '0;
        case (scan_mode)
            SCAN_BETWEEN: begin
                if (b == CH_NUL) begin
                    mark_token();
                    tok = make_token(gtl_pkg::KIND_END, gtl_pkg::ERR_NONE, 14'd0);
                    scan_mode = SCAN_HALTED;
                    hit = 1'b1;
                end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
                    advance_pos(b);
                end else if (b == CH_HASH) begin
                    scan_mode = SCAN_COMMENT;
                    advance_pos(b);
                end else begin
                    mark_token();
                    if (b == CH_LT || b == CH_DQUOTE || b == CH_SQUOTE) begin
                        scan_mode = (b == CH_LT) ? SCAN_ANGLE :
                                    (b == CH_DQUOTE) ? SCAN_DQUOTE : SCAN_SQUOTE;
                        advance_pos(b);
                    end else if (b == CH_COLON || b == CH_PIPE || b == CH_SEMI) begin
                        tok = make_token(b == CH_COLON ? gtl_pkg::KIND_PRODUCE :
                                         b == CH_PIPE ? gtl_pkg::KIND_PIPE :
                                         gtl_pkg::KIND_SEMI,
                                         gtl_pkg::ERR_NONE, 14'd1);
                        advance_pos(b);
                        hit = 1'b1;
                    end else begin
                        tok = make_token(gtl_pkg::KIND_ERROR, gtl_pkg::ERR_BYTE, 14'd1);
                        scan_mode = SCAN_HALTED;
                        hit = 1'b1;
                    end
                end
            end
            SCAN_ANGLE: begin
                if (is_name_char(b)) begin
                    advance_pos(b);
                end else if (b == CH_GT) begin
                    tok = make_token(gtl_pkg::KIND_NONTERM, gtl_pkg::ERR_NONE, span + 14'd1);
                    scan_mode = SCAN_BETWEEN;
                    advance_pos(b);
                    hit = 1'b1;
                end else begin
                    // a zero byte is not counted in the error length
                    tok = make_token(gtl_pkg::KIND_ERROR, gtl_pkg::ERR_ANGLE,
                                     b == CH_NUL ? span : span + 14'd1);
                    scan_mode = SCAN_HALTED;
                    hit = 1'b1;
                end
            end
            SCAN_DQUOTE, SCAN_SQUOTE: begin
                if (b == (scan_mode == SCAN_DQUOTE ? CH_DQUOTE : CH_SQUOTE)) begin
                    tok = make_token(gtl_pkg::KIND_TERM, gtl_pkg::ERR_NONE, span + 14'd1);
                    scan_mode = SCAN_BETWEEN;
                    advance_pos(b);
                    hit = 1'b1;
                end else if (b == CH_NUL || b == CH_LF) begin
                    tok = make_token(gtl_pkg::KIND_ERROR, gtl_pkg::ERR_QUOTE,
                                     b == CH_NUL ? span : span + 14'd1);
                    scan_mode = SCAN_HALTED;
                    hit = 1'b1;
                end else begin
                    advance_pos(b);
                end
            end
            SCAN_COMMENT: begin
                if (b == CH_NUL) begin
                    mark_token();
                    tok = make_token(gtl_pkg::KIND_END, gtl_pkg::ERR_NONE, 14'd0);
                    scan_mode = SCAN_HALTED;
                    hit = 1'b1;
                end else begin
                    if (b == CH_LF) scan_mode = SCAN_BETWEEN;
                    advance_pos(b);
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    task automatic push_byte(logic [7:0] b);
        grammar_text.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Any byte but zero, newline and the given stop byte
    task automatic push_filler(logic [7:0] stop);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == stop);
        push_byte(b);
    endtask

    task automatic push_name_chars(int n);
        repeat (n) push_byte(NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)]);
    endtask

    // Append one well-formed piece of grammar text
    task automatic push_piece();
        int         pick;
        logic [7:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            push_byte(CH_LT);
            push_name_chars($urandom_range(0, 10));
            push_byte(CH_GT);
        end else if (pick < 50) begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            push_byte(q);
            repeat ($urandom_range(0, 8)) push_filler(q);
            push_byte(q);
        end else if (pick < 75) begin
            case ($urandom_range(0, 2))
                0: push_byte(CH_COLON);
                1: push_byte(CH_PIPE);
                default: push_byte(CH_SEMI);
            endcase
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: push_byte(CH_SPACE);
                    1: push_byte(CH_TAB);
                    default: push_byte(CH_LF);
                endcase
            end
        end else begin
            push_byte(CH_HASH);
            repeat ($urandom_range(0, 12)) push_filler(CH_LF);
            push_byte(CH_LF);
        end
    endtask

    task automatic push_grammar(int n);
        int goal;
        goal = bytes_queued + n;
        while (bytes_queued < goal) push_piece();
    endtask

    // Finish the text with one randomly chosen way to end or fail
    task automatic push_ending();
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0: begin
                end_desc = "end between tokens";
                push_byte(CH_NUL);
            end
            1: begin
                end_desc = "end inside a comment";
                push_text("#tail");
                push_byte(CH_NUL);
            end
            2: begin
                end_desc = "end inside a quote";
                push_text("\"ab");
                push_byte(CH_NUL);
            end
            3: begin
                end_desc = "end inside an angle";
                push_text("<ab");
                push_byte(CH_NUL);
            end
            4: begin
                end_desc = "newline inside a quote";
                push_text("'ab");
                push_byte(CH_LF);
            end
            5: begin
                end_desc = "bad byte inside an angle";
                push_text("<ab");
                do b = 8'($urandom_range(1, 255)); while (is_name_char(b) || b == CH_GT);
                push_byte(b);
            end
            default: begin
                end_desc = "unexpected byte between tokens";
                do b = 8'($urandom_range(1, 255));
                while (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_HASH ||
                       b == CH_LT || b == CH_DQUOTE || b == CH_SQUOTE ||
                       b == CH_COLON || b == CH_PIPE || b == CH_SEMI);
                push_byte(b);
            end
        endcase
        // the lexer has halted: these must all be dropped
        repeat (30) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (grammar_text.size() != 0 || i_in_valid || pending_tokens.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: offer the next byte, hold it while stalled
    always @(posedge i_clk) begin
        gtl_pkg::t_token tok;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                bytes_fed++;
                if (scan_byte(i_text_byte, tok)) pending_tokens.push_back(tok);
            end
            if (grammar_text.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_text_byte <= grammar_text.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off at the start of the last phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (run_phase == 3 && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count++;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Score each token transaction against the oldest prediction
    always @(posedge i_clk) begin
        gtl_pkg::t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected token: kind %0d offset %0d", o_token_kind, o_start_offset);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                tokens_seen++;
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    mismatches++;
                end
                if (o_error_kind !== want.err) begin
                    $error("error_kind: expected %0d, got %0d", want.err, o_error_kind);
                    mismatches++;
                end
                if (o_start_offset !== want.start) begin
                    $error("start_offset: expected %0d, got %0d", want.start, o_start_offset);
                    mismatches++;
                end
                if (o_token_length !== want.len) begin
                    $error("token_length: expected %0d, got %0d", want.len, o_token_length);
                    mismatches++;
                end
                if (o_start_line !== want.line) begin
                    $error("start_line: expected %0d, got %0d", want.line, o_start_line);
                    mismatches++;
                end
                if (o_start_column !== want.col) begin
                    $error("start_column: expected %0d, got %0d", want.col, o_start_column);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 1: directed corners, then random grammar; sender busy, receiver lazy
        run_phase     = 1;
        send_idle_pct = 13;
        recv_idle_pct = 88;
        push_text("<><Az-09>");
        push_text("\"\"'':|;");
        push_text(" \t\n");
        push_text("'\"");
        push_byte(8'hFF);
        push_byte(8'h80);
        push_text("'");
        push_byte(CH_HASH);
        push_byte(8'hFF);
        push_text("x\n");
        push_grammar(620);
        wait_drained();
        repeat (4) @(negedge i_clk);

        // Phase 2: sender lazy, receiver busy
        run_phase     = 2;
        send_idle_pct = 88;
        recv_idle_pct = 13;
        push_grammar(620);
        wait_drained();

        // Phase 3: full rate, long hold-off, then the ending
        run_phase     = 3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_grammar(580);
        push_grammar(60);
        push_ending();
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (pending_tokens.size() != 0) begin
            $error("%0d predicted tokens never arrived", pending_tokens.size());
            mismatches++;
        end
        $display("Fed %0d text bytes under three stall mixes, checked %0d tokens.",
                 bytes_fed, tokens_seen);
        $display("Text ended with: %s; later bytes were dropped.", end_desc);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gtl_pkg.sv
hw/rtl/gtl_scan.sv
hw/rtl/grammar_token_lexer.sv
test/grammar_token_lexer_test.sv
